// ===== rtl/greedy_word_wrap_measurer_assert.svh =====
// Assertion macros used by the checker file of the word wrap measurer.
`ifndef GREEDY_WORD_WRAP_MEASURER_ASSERT_SVH
`define GREEDY_WORD_WRAP_MEASURER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define GWWM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define GWWM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/gwwm_pkg.sv =====
// Shared constants, codes and types of the word wrap measurer.
package gwwm_pkg;

	localparam int TABLE_DEPTH_DEF  = 256;
	localparam int ADVANCE_BITS_DEF = 10;
	localparam int WIDTH_BITS_DEF   = 24;

	localparam int CODE_W   = 8;
	localparam int ADV_IN_W = 10;
	localparam int LIMIT_W  = 24;
	localparam int SCALE_W  = 10;
	localparam int FRAC_W   = 8;
	localparam int MAXW_W   = 24;
	localparam int COUNT_W  = 16;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [CODE_W-1:0]  SPACE_CODE     = 8'd32;
	localparam logic [LIMIT_W-1:0] WRAP_LIMIT_RST = 24'hFFFFFF;
	localparam logic [SCALE_W-1:0] SCALE_RST      = 10'd256;

	typedef enum logic {
		REG_WRAP_LIMIT    = 1'b0,
		REG_SPACING_SCALE = 1'b1
	} reg_idx_t;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_CHAR = 1'b1
	} kind_t;

	typedef struct packed {
		logic is_space;
		logic last;
		logic in_range;
	} item_info_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] wrap_limit;
		logic [SCALE_W-1:0] spacing_scale;
	} cfg_t;

endpackage

// ===== rtl/gwwm_if.sv =====
// Valid/ready channel interfaces for character beats and result beats.
interface gwwm_char_if;
	import gwwm_pkg::*;
	logic                valid;
	logic                ready;
	logic                kind;
	logic [CODE_W-1:0]   char_code;
	logic [ADV_IN_W-1:0] advance_value;
	logic                last;

	modport source(output valid, kind, char_code, advance_value, last, input ready);
	modport sink(input valid, kind, char_code, advance_value, last, output ready);
endinterface

interface gwwm_result_if;
	import gwwm_pkg::*;
	logic               valid;
	logic               ready;
	logic [MAXW_W-1:0]  max_width;
	logic [COUNT_W-1:0] line_count;

	modport source(output valid, max_width, line_count, input ready);
	modport sink(input valid, max_width, line_count, output ready);
endinterface

// ===== rtl/gwwm_cfg.sv =====
// APB-style register file holding wrap limit and spacing scale.
module gwwm_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gwwm_pkg::PADDR_W-1:0] paddr,
	input  logic [gwwm_pkg::PDATA_W-1:0] pwdata,
	output logic [gwwm_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output gwwm_pkg::cfg_t               cfg
);
	import gwwm_pkg::*;

	reg_idx_t           idx;
	logic               wr;
	logic [LIMIT_W-1:0] wrap_limit_q;
	logic [SCALE_W-1:0] scale_q;

	// decode the word address; byte offset bits are ignored
	assign idx    = reg_idx_t'(paddr[PADDR_W-1]);
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	// write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_limit_q <= WRAP_LIMIT_RST;
			scale_q      <= SCALE_RST;
		end else if (wr) begin
			case (idx)
				REG_WRAP_LIMIT:    wrap_limit_q <= pwdata[LIMIT_W-1:0];
				REG_SPACING_SCALE: scale_q      <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_WRAP_LIMIT:    prdata = {{(PDATA_W-LIMIT_W){1'b0}}, wrap_limit_q};
			REG_SPACING_SCALE: prdata = {{(PDATA_W-SCALE_W){1'b0}}, scale_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg.wrap_limit    = wrap_limit_q;
	assign cfg.spacing_scale = scale_q;
endmodule

// ===== rtl/gwwm_adv_table.sv =====
// Advance table memory: load beats write it, character beats read it.
module gwwm_adv_table #(
	parameter int TABLE_DEPTH  = gwwm_pkg::TABLE_DEPTH_DEF,
	parameter int ADVANCE_BITS = gwwm_pkg::ADVANCE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          accept,
	input  logic                          kind,
	input  logic [gwwm_pkg::CODE_W-1:0]   char_code,
	input  logic [gwwm_pkg::ADV_IN_W-1:0] advance_value,
	input  logic                          last,
	output logic [ADVANCE_BITS-1:0]       rd_data,
	output logic                          valid_s1,
	output gwwm_pkg::item_info_t          info_s1
);
	import gwwm_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic [ADVANCE_BITS-1:0]          mem [TABLE_DEPTH];
	logic [IDX_W-1:0]                 idx;
	logic                             in_range;
	logic                             is_load;
	logic [ADV_IN_W+ADVANCE_BITS-1:0] adv_ext;
	logic [ADVANCE_BITS-1:0]          adv_w;

	assign idx      = char_code[IDX_W-1:0];
	assign in_range = {1'b0, char_code} < (CODE_W+1)'(TABLE_DEPTH);
	assign is_load  = kind_t'(kind) == KIND_LOAD;
	assign adv_ext  = {{ADVANCE_BITS{1'b0}}, advance_value};
	assign adv_w    = adv_ext[ADVANCE_BITS-1:0];

	// write loads, read for the next stage while advancing
	always_ff @(posedge clk) begin
		if (accept && is_load && in_range) begin
			mem[idx] <= adv_w;
		end
		if (en) begin
			rd_data <= mem[idx];
		end
	end

	// stage 1 valid: only character beats travel on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept && !is_load;
		end
	end

	// stage 1 side info
	always_ff @(posedge clk) begin
		if (en) begin
			info_s1.is_space <= char_code == SPACE_CODE;
			info_s1.last     <= last;
			info_s1.in_range <= in_range;
		end
	end
endmodule

// ===== rtl/gwwm_scaler.sv =====
// Scale the looked-up advance by spacing_scale, truncate and clamp.
module gwwm_scaler #(
	parameter int ADVANCE_BITS = gwwm_pkg::ADVANCE_BITS_DEF,
	parameter int WIDTH_BITS   = gwwm_pkg::WIDTH_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [gwwm_pkg::SCALE_W-1:0] spacing_scale,
	input  logic [ADVANCE_BITS-1:0]      rd_data,
	input  logic                         valid_s1,
	input  gwwm_pkg::item_info_t         info_s1,
	output logic [WIDTH_BITS-1:0]        scaled_s2,
	output logic                         valid_s2,
	output gwwm_pkg::item_info_t         info_s2
);
	import gwwm_pkg::*;

	localparam int PROD_W   = ADVANCE_BITS + SCALE_W;
	localparam int SCALED_W = PROD_W - FRAC_W;
	localparam int EXT_W    = (SCALED_W > WIDTH_BITS) ? SCALED_W : WIDTH_BITS;
	localparam logic [WIDTH_BITS-1:0] WMAX = {WIDTH_BITS{1'b1}};

	logic [ADVANCE_BITS-1:0] adv;
	logic [PROD_W-1:0]       prod;
	logic [EXT_W-1:0]        shifted;
	logic [WIDTH_BITS-1:0]   clamped;

	// out-of-range codes count as zero advance
	assign adv     = info_s1.in_range ? rd_data : '0;
	assign prod    = PROD_W'(adv) * PROD_W'(spacing_scale);
	assign shifted = EXT_W'(prod[PROD_W-1:FRAC_W]);
	assign clamped = (shifted > EXT_W'(WMAX)) ? WMAX : shifted[WIDTH_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scaled_s2 <= clamped;
			info_s2   <= info_s1;
		end
	end
endmodule

// ===== rtl/gwwm_accum.sv =====
// Running line state, break at last space, and the result register.
module gwwm_accum #(
	parameter int WIDTH_BITS = gwwm_pkg::WIDTH_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [gwwm_pkg::LIMIT_W-1:0] wrap_limit,
	input  logic [WIDTH_BITS-1:0]        scaled_s2,
	input  logic                         valid_s2,
	input  gwwm_pkg::item_info_t         info_s2,
	input  logic                         out_ready,
	output logic                         hold,
	output logic                         out_valid_q,
	output logic [gwwm_pkg::MAXW_W-1:0]  max_width_q,
	output logic [gwwm_pkg::COUNT_W-1:0] line_count_q
);
	import gwwm_pkg::*;

	localparam int CMP_W = (WIDTH_BITS > LIMIT_W) ? WIDTH_BITS : LIMIT_W;
	localparam logic [WIDTH_BITS-1:0] WMAX = {WIDTH_BITS{1'b1}};
	localparam logic [COUNT_W-1:0]    CMAX = {COUNT_W{1'b1}};

	logic [WIDTH_BITS-1:0] line_width_q, before_q, after_q, widest_q;
	logic                  seen_q;
	logic [COUNT_W-1:0]    lines_q;

	logic                  fire, brk;
	logic [WIDTH_BITS-1:0] lw_brk, widest_brk, lw_n, before_n, after_n, widest_fin;
	logic                  seen_n;
	logic [COUNT_W-1:0]    lines_n;
	logic [MAXW_W+WIDTH_BITS-1:0] widest_ext;

	function automatic logic [WIDTH_BITS-1:0] sat_add(
		input logic [WIDTH_BITS-1:0] a,
		input logic [WIDTH_BITS-1:0] b
	);
		logic [WIDTH_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WIDTH_BITS] ? WMAX : s[WIDTH_BITS-1:0];
	endfunction

	// stall the pipe only when a result is due and the slot is full
	assign hold = valid_s2 && info_s2.last && out_valid_q && !out_ready;
	assign fire = valid_s2 && !hold;

	// break at the last space, then add this character
	always_comb begin
		brk        = (CMP_W'(line_width_q) > CMP_W'(wrap_limit)) && seen_q;
		lw_brk     = brk ? after_q : line_width_q;
		widest_brk = (brk && (before_q > widest_q)) ? before_q : widest_q;
		lines_n    = (brk && (lines_q != CMAX)) ? lines_q + 1'b1 : lines_q;
		if (info_s2.is_space) begin
			before_n = lw_brk;
			after_n  = '0;
			seen_n   = 1'b1;
		end else begin
			before_n = before_q;
			after_n  = sat_add(after_q, scaled_s2);
			seen_n   = seen_q && !brk;
		end
		lw_n       = sat_add(lw_brk, scaled_s2);
		widest_fin = (lw_n > widest_brk) ? lw_n : widest_brk;
		widest_ext = {{MAXW_W{1'b0}}, widest_fin};
	end

	// hold running state; clear after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= '0;
			before_q     <= '0;
			after_q      <= '0;
			seen_q       <= 1'b0;
			widest_q     <= '0;
			lines_q      <= COUNT_W'(1);
			out_valid_q  <= 1'b0;
		end else begin
			if (fire) begin
				if (info_s2.last) begin
					line_width_q <= '0;
					before_q     <= '0;
					after_q      <= '0;
					seen_q       <= 1'b0;
					widest_q     <= '0;
					lines_q      <= COUNT_W'(1);
				end else begin
					line_width_q <= lw_n;
					before_q     <= before_n;
					after_q      <= after_n;
					seen_q       <= seen_n;
					widest_q     <= widest_brk;
					lines_q      <= lines_n;
				end
			end
			if (fire && info_s2.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire && info_s2.last) begin
			max_width_q  <= widest_ext[MAXW_W-1:0];
			line_count_q <= lines_n;
		end
	end
endmodule

// ===== rtl/greedy_word_wrap_measurer.sv =====
// Pipeline: a last character passes the table read register, the scaler register and the result register.
// Throughput: one beat per cycle while the pipe is not stalled, loads and characters alike; the table has one
// write and one registered read per cycle, and the line state register updates for each character that fires.
// The pipe stalls only while a result waits and the next last character reaches it.
// Reset: arst_n clears pipe valids, line state and registers; the advance table
// has no reset and stays undefined until loaded.
module greedy_word_wrap_measurer #(
	parameter int TABLE_DEPTH  = gwwm_pkg::TABLE_DEPTH_DEF,
	parameter int ADVANCE_BITS = gwwm_pkg::ADVANCE_BITS_DEF,
	parameter int WIDTH_BITS   = gwwm_pkg::WIDTH_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gwwm_pkg::PADDR_W-1:0] paddr,
	input  logic [gwwm_pkg::PDATA_W-1:0] pwdata,
	output logic [gwwm_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	gwwm_char_if.sink                    char_in,
	gwwm_result_if.source                result_out
);
	import gwwm_pkg::*;

	cfg_t                    cfg;
	logic                    en, hold, accept;
	logic [ADVANCE_BITS-1:0] rd_data;
	logic                    valid_s1, valid_s2;
	item_info_t              info_s1, info_s2;
	logic [WIDTH_BITS-1:0]   scaled_s2;

	// advance the pipe unless a result is blocked
	assign en             = !hold;
	assign char_in.ready  = en;
	assign accept         = char_in.valid && en;

	gwwm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gwwm_adv_table #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.ADVANCE_BITS (ADVANCE_BITS)
	) u_table (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.accept        (accept),
		.kind          (char_in.kind),
		.char_code     (char_in.char_code),
		.advance_value (char_in.advance_value),
		.last          (char_in.last),
		.rd_data       (rd_data),
		.valid_s1      (valid_s1),
		.info_s1       (info_s1)
	);

	gwwm_scaler #(
		.ADVANCE_BITS (ADVANCE_BITS),
		.WIDTH_BITS   (WIDTH_BITS)
	) u_scaler (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.spacing_scale (cfg.spacing_scale),
		.rd_data       (rd_data),
		.valid_s1      (valid_s1),
		.info_s1       (info_s1),
		.scaled_s2     (scaled_s2),
		.valid_s2      (valid_s2),
		.info_s2       (info_s2)
	);

	gwwm_accum #(
		.WIDTH_BITS (WIDTH_BITS)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.wrap_limit   (cfg.wrap_limit),
		.scaled_s2    (scaled_s2),
		.valid_s2     (valid_s2),
		.info_s2      (info_s2),
		.out_ready    (result_out.ready),
		.hold         (hold),
		.out_valid_q  (result_out.valid),
		.max_width_q  (result_out.max_width),
		.line_count_q (result_out.line_count)
	);
endmodule

// ===== rtl/gwwm_checker.sv =====
// Port-level checker of the word wrap measurer and its bind.
`include "greedy_word_wrap_measurer_assert.svh"

module gwwm_port_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [gwwm_pkg::MAXW_W-1:0]  max_width,
	input logic [gwwm_pkg::COUNT_W-1:0] line_count
);
	import gwwm_pkg::*;

	logic                        stall;
	logic [MAXW_W+COUNT_W-1:0]   payload;

	assign stall   = out_valid && !out_ready;
	assign payload = {max_width, line_count};

	// a waiting result beat holds its payload
	`GWWM_ASSERT_NXT(a_out_hold, stall, out_valid && $stable(payload), "stalled result changed")

	// with the result slot empty the input never stalls
	`GWWM_ASSERT_IMP(a_in_free, !out_valid, in_ready, "input stalled with empty result slot")

	// every string has at least one line
	`GWWM_ASSERT_IMP(a_count_nonzero, out_valid, line_count != '0, "line count is zero")
endmodule

bind greedy_word_wrap_measurer gwwm_port_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (char_in.ready),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.max_width  (result_out.max_width),
	.line_count (result_out.line_count)
);
